>>> rtl/kens_pkg.sv
// Kepler Newton solver package: payload types, datapath command codes,
// fixed-point constants, and the CORDIC angle table and gain built at elaboration.
// No dependencies.
package kens_pkg;

  localparam int ANGLE_FRAC_BITS = 40;
  localparam int CORDIC_STAGES   = 44;
  localparam int INT_FRAC        = 60;
  localparam int TO_ANGLE_SHIFT  = INT_FRAC - ANGLE_FRAC_BITS;
  localparam int ANGLE_W         = 48;
  localparam int ECC_W           = 32;
  localparam int WORD_W          = 64;
  localparam int HALF_W          = WORD_W / 2;
  localparam int COUNT_W         = 8;
  localparam int STEP_TOL_W      = 20;
  localparam int RESID_TOL_W     = 24;
  localparam int CFG_DATA_W      = 24;
  localparam int CFG_IDX_W       = 2;
  localparam int DIV_BITS        = WORD_W;
  localparam int CNT_W           = $clog2(DIV_BITS);
  // Quotient of |angle| / 2pi stays below 2^RED_STEPS for a 48-bit angle.
  localparam int RED_STEPS = (ANGLE_W - 3 - ANGLE_FRAC_BITS > 0) ?
                             (ANGLE_W - 3 - ANGLE_FRAC_BITS) : 1;

  localparam logic [STEP_TOL_W-1:0]  STEP_TOL_RST  = STEP_TOL_W'(110);
  localparam logic [COUNT_W-1:0]     ITER_LIM_RST  = COUNT_W'(100);
  localparam logic [RESID_TOL_W-1:0] RESID_TOL_RST = RESID_TOL_W'(191900);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_TOL   = 2'd0,
    CFG_ITER_LIMIT = 2'd1,
    CFG_RESID_TOL  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] mean_anomaly;
    logic [ECC_W-1:0]          eccentricity;
  } in_item_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] eccentric_anomaly;
    logic                      solution_valid;
    logic [COUNT_W-1:0]        iterations_used;
    logic                      limit_reached;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED_INIT,
    OP_RED_STEP,
    OP_RED_SIGN,
    OP_FOLD_PI,
    OP_FOLD_HALF,
    OP_CORDIC,
    OP_MUL_PREP,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_MUL_SIGN,
    OP_START,
    OP_FUNC,
    OP_DERIV,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_CAP,
    OP_DELTA,
    OP_UPDATE,
    OP_RESID,
    OP_RESID_CHK,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t             op;
    logic [CNT_W-1:0]   idx;
    logic               sel_ea;
    logic               sel_cos;
    logic [COUNT_W-1:0] count;
    logic               not_conv;
  } dp_cmd_t;

  typedef struct packed {
    logic step_small;
  } dp_status_t;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [CORDIC_STAGES-1:0] atan_tab_t;

  // Elaboration-time helpers: shift-subtract division of hi:lo by d,
  // saturating to all ones when the quotient does not fit.
  function automatic word_t f_udiv(word_t hi, word_t lo, word_t d);
    word_t r;
    word_t l;
    word_t q;
    logic  top;
    r = hi;
    l = lo;
    q = '0;
    if (d == '0 || hi >= d) return '1;
    for (int k = 0; k < WORD_W; k++) begin
      top = r[WORD_W-1];
      r   = {r[WORD_W-2:0], l[WORD_W-1]};
      l   = {l[WORD_W-2:0], 1'b0};
      q   = {q[WORD_W-2:0], 1'b0};
      if (top || r >= d) begin
        r    = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic word_t f_alt_series(word_t t0, word_t divisor, int shift);
    word_t t;
    word_t sum;
    word_t term;
    t   = t0;
    sum = '0;
    for (int k = 0; k < WORD_W; k++) begin
      if (t != '0) begin
        term = f_udiv('0, t, word_t'(2 * k + 1));
        if (k[0]) sum = sum - term;
        else      sum = sum + term;
        if (divisor != '0) t = f_udiv('0, t, divisor);
        else if (shift < WORD_W) t = t >> shift;
        else t = '0;
      end
    end
    return sum;
  endfunction

  function automatic word_t f_to_angle(word_t v);
    word_t rnd;
    rnd = word_t'(1) << (TO_ANGLE_SHIFT - 1);
    return (v + rnd) >> TO_ANGLE_SHIFT;
  endfunction

  // pi/4 in 2^-60 units (Machin series)
  function automatic word_t f_quarter();
    word_t one;
    word_t a;
    word_t b;
    one = word_t'(1) << INT_FRAC;
    a   = f_alt_series(f_udiv('0, one, word_t'(5)), word_t'(25), 0);
    b   = f_alt_series(f_udiv('0, one, word_t'(239)), word_t'(57121), 0);
    return (a << 2) - b;
  endfunction

  function automatic atan_tab_t f_atan_tab();
    atan_tab_t tab;
    word_t     t0;
    tab[0] = f_to_angle(f_quarter());
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      t0 = (i <= INT_FRAC) ? (word_t'(1) << (INT_FRAC - i)) : '0;
      tab[i] = f_to_angle(f_alt_series(t0, '0, 2 * i));
    end
    return tab;
  endfunction

  // Inverse CORDIC gain: Newton square root of the stage product.
  function automatic word_t f_gain_inv();
    word_t p;
    word_t s;
    word_t q;
    word_t ns;
    logic  done;
    p    = word_t'(1) << (INT_FRAC + 1);
    s    = word_t'(1) << (INT_FRAC + 1);
    done = 1'b0;
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      if (2 * i < WORD_W) p = p + (p >> (2 * i));
    end
    for (int k = 0; k < 80; k++) begin
      if (!done) begin
        q  = f_udiv(p >> 4, p << 60, s);
        ns = (s + q) >> 1;
        if (ns >= s) done = 1'b1;
        else s = ns;
      end
    end
    return f_udiv(word_t'(1) << 56, '0, s);
  endfunction

  localparam word_t QUARTER = f_quarter();
  localparam logic signed [WORD_W-1:0] PI_A      = signed'(f_to_angle(QUARTER << 2));
  localparam logic signed [WORD_W-1:0] HALF_PI_A = signed'(f_to_angle(QUARTER << 1));
  localparam logic signed [WORD_W-1:0] TWO_PI_A  = signed'(f_to_angle(QUARTER << 3));
  localparam logic signed [WORD_W-1:0] GAIN_INV  = signed'(f_gain_inv());
  localparam atan_tab_t ATAN_TAB = f_atan_tab();

  localparam logic signed [WORD_W-1:0] ONE_INT  = signed'(word_t'(1) << INT_FRAC);
  localparam word_t                    STEP_CAP = word_t'(1) << 50;
  localparam logic signed [WORD_W-1:0] E_MAX    = signed'((word_t'(1) << (ANGLE_W - 1)) - 1);
  localparam logic signed [WORD_W-1:0] E_MIN    = -signed'(word_t'(1) << (ANGLE_W - 1));

  function automatic logic signed [WORD_W-1:0] sat48(logic signed [WORD_W-1:0] v);
    if (v > E_MAX) return E_MAX;
    if (v < E_MIN) return E_MIN;
    return v;
  endfunction

endpackage

>>> rtl/kens_datapath.sv
// Kepler Newton solver datapath: angle reduction, CORDIC sin/cos, shared 32x32
// multiplier, restoring divider and Newton update. Driven by kens_ctrl; uses kens_pkg.
module kens_datapath (
  input  logic                                  clk,
  input  kens_pkg::dp_cmd_t                     cmd,
  input  kens_pkg::in_item_t                    in_data,
  input  logic [kens_pkg::STEP_TOL_W-1:0]       step_tol,
  input  logic [kens_pkg::RESID_TOL_W-1:0]      resid_tol,
  output kens_pkg::dp_status_t                  status,
  output kens_pkg::out_item_t                   out_data
);
  import kens_pkg::*;

  logic signed [WORD_W-1:0] m_r, ea_r, old_ea_r, ang_r, x_r, y_r;
  logic signed [WORD_W-1:0] emul_r, f_r, fp_r, delta_r, res_r;
  logic [ECC_W-1:0]         e_r;
  logic                     aneg_r, flip_r, mneg_r, dsat_r, res_ok_r;
  word_t                    mag_r, acc_r, rem_r, num_r, quo_r;
  out_item_t                out_r;

  logic signed [WORD_W-1:0] ang_src, red_sub, dx, dy, atan_v, vsel, es;
  logic signed [WORD_W-1:0] deriv, fmag_s, step_d, sum_v;
  logic signed [WORD_W-1:0] stol_s, rtol_s;
  logic [HALF_W-1:0]        mul_b;
  word_t                    prod, qv;
  logic [WORD_W+1:0]        div_diff;

  assign ang_src = cmd.sel_ea ? ea_r : m_r;
  assign red_sub = TWO_PI_A <<< cmd.idx;
  assign dx      = y_r >>> cmd.idx;
  assign dy      = x_r >>> cmd.idx;
  assign atan_v  = signed'(ATAN_TAB[cmd.idx]);
  assign vsel    = cmd.sel_cos ? x_r : y_r;
  assign mul_b   = (cmd.op == OP_MUL_LO) ? mag_r[HALF_W-1:0] : mag_r[WORD_W-1:HALF_W];
  assign prod    = word_t'(e_r) * word_t'(mul_b);
  assign es      = emul_r >>> TO_ANGLE_SHIFT;
  assign deriv   = ONE_INT - emul_r;
  assign fmag_s  = f_r[WORD_W-1] ? -f_r : f_r;
  assign div_diff = {1'b0, rem_r, num_r[WORD_W-1]} - {2'b00, fp_r};
  assign qv      = dsat_r ? '1 : quo_r;
  assign sum_v   = m_r + es;
  assign step_d  = ea_r - old_ea_r;
  assign stol_s  = signed'(word_t'(step_tol));
  assign rtol_s  = signed'(word_t'(resid_tol));

  assign status.step_small = (step_d <= stol_s) && (step_d >= -stol_s);
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        m_r <= {{(WORD_W-ANGLE_W){in_data.mean_anomaly[ANGLE_W-1]}}, in_data.mean_anomaly};
        e_r <= in_data.eccentricity;
      end
      OP_RED_INIT: begin
        aneg_r <= ang_src[WORD_W-1];
        ang_r  <= ang_src[WORD_W-1] ? -ang_src : ang_src;
      end
      OP_RED_STEP: begin
        if (ang_r >= red_sub) ang_r <= ang_r - red_sub;
      end
      OP_RED_SIGN: begin
        if (aneg_r) ang_r <= -ang_r;
      end
      OP_FOLD_PI: begin
        if (ang_r > PI_A) ang_r <= ang_r - TWO_PI_A;
        else if (ang_r < -PI_A) ang_r <= ang_r + TWO_PI_A;
      end
      OP_FOLD_HALF: begin
        if (ang_r > HALF_PI_A) begin
          ang_r  <= PI_A - ang_r;
          flip_r <= 1'b1;
        end else if (ang_r < -HALF_PI_A) begin
          ang_r  <= -PI_A - ang_r;
          flip_r <= 1'b1;
        end else begin
          flip_r <= 1'b0;
        end
        x_r <= GAIN_INV;
        y_r <= '0;
      end
      OP_CORDIC: begin
        if (!ang_r[WORD_W-1]) begin
          x_r   <= x_r - dx;
          y_r   <= y_r + dy;
          ang_r <= ang_r - atan_v;
        end else begin
          x_r   <= x_r + dx;
          y_r   <= y_r - dy;
          ang_r <= ang_r + atan_v;
        end
      end
      OP_MUL_PREP: begin
        // cos is -x when the angle was folded; only the sign flips
        mag_r  <= vsel[WORD_W-1] ? word_t'(-vsel) : word_t'(vsel);
        mneg_r <= vsel[WORD_W-1] ^ (cmd.sel_cos & flip_r);
      end
      OP_MUL_LO: acc_r <= prod;
      OP_MUL_HI: acc_r <= prod + {{HALF_W{1'b0}}, acc_r[WORD_W-1:HALF_W]};
      OP_MUL_SIGN: emul_r <= mneg_r ? -signed'(acc_r) : signed'(acc_r);
      OP_START: ea_r <= sat48(sum_v);
      OP_FUNC: f_r <= ea_r - m_r - es;
      OP_DERIV: begin
        fp_r  <= (deriv < 1) ? signed'(word_t'(1)) : deriv;
        rem_r <= word_t'(fmag_s) >> 4;
        num_r <= word_t'(fmag_s) << INT_FRAC;
        quo_r <= '0;
      end
      OP_DIV_INIT: dsat_r <= rem_r >= word_t'(fp_r);
      OP_DIV_STEP: begin
        num_r <= {num_r[WORD_W-2:0], 1'b0};
        if (!div_diff[WORD_W+1]) begin
          rem_r <= div_diff[WORD_W-1:0];
          quo_r <= {quo_r[WORD_W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[WORD_W-2:0], num_r[WORD_W-1]};
          quo_r <= {quo_r[WORD_W-2:0], 1'b0};
        end
      end
      OP_CAP: quo_r <= (qv > STEP_CAP) ? STEP_CAP : qv;
      OP_DELTA: delta_r <= f_r[WORD_W-1] ? -signed'(quo_r) : signed'(quo_r);
      OP_UPDATE: begin
        old_ea_r <= ea_r;
        ea_r     <= sat48(ea_r - delta_r);
      end
      OP_RESID: res_r <= ea_r - es - m_r;
      OP_RESID_CHK: res_ok_r <= (res_r <= rtol_s) && (res_r >= -rtol_s);
      OP_EMIT: begin
        out_r.eccentric_anomaly <= ea_r[ANGLE_W-1:0];
        out_r.solution_valid    <= res_ok_r;
        out_r.iterations_used   <= cmd.count;
        out_r.limit_reached     <= cmd.not_conv;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/kens_ctrl.sv
// Kepler Newton solver controller: sequences reduction, CORDIC, multiply,
// divide and update steps, and owns the handshakes. Uses kens_pkg.
module kens_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  logic [kens_pkg::COUNT_W-1:0]  iter_limit,
  input  kens_pkg::dp_status_t          status,
  output kens_pkg::dp_cmd_t             cmd
);
  import kens_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_RED_INIT, S_RED_STEP, S_RED_SIGN, S_FOLD_PI, S_FOLD_HALF, S_CORDIC,
    S_MUL_PREP, S_MUL_LO, S_MUL_HI, S_MUL_SIGN, S_START, S_LOOP, S_FUNC, S_DERIV,
    S_DIV_INIT, S_DIV_STEP, S_CAP, S_DELTA, S_UPDATE, S_STEP_CHK, S_RESID,
    S_RESID_CHK, S_EMIT
  } state_t;

  typedef enum logic [1:0] {PH_START, PH_SIN, PH_COS, PH_RESID} phase_t;

  state_t             state_r;
  phase_t             phase_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [COUNT_W-1:0] count_r;
  logic               conv_r;
  logic               out_valid_r;
  logic               emit_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign emit_ok   = !out_valid_r || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.idx      = cnt_r;
    cmd.sel_ea   = (phase_r != PH_START);
    cmd.sel_cos  = (phase_r == PH_COS);
    cmd.count    = count_r;
    cmd.not_conv = !conv_r;
    case (state_r)
      S_IDLE:      cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_RED_INIT:  cmd.op = OP_RED_INIT;
      S_RED_STEP:  cmd.op = OP_RED_STEP;
      S_RED_SIGN:  cmd.op = OP_RED_SIGN;
      S_FOLD_PI:   cmd.op = OP_FOLD_PI;
      S_FOLD_HALF: cmd.op = OP_FOLD_HALF;
      S_CORDIC:    cmd.op = OP_CORDIC;
      S_MUL_PREP:  cmd.op = OP_MUL_PREP;
      S_MUL_LO:    cmd.op = OP_MUL_LO;
      S_MUL_HI:    cmd.op = OP_MUL_HI;
      S_MUL_SIGN:  cmd.op = OP_MUL_SIGN;
      S_START:     cmd.op = OP_START;
      S_FUNC:      cmd.op = OP_FUNC;
      S_DERIV:     cmd.op = OP_DERIV;
      S_DIV_INIT:  cmd.op = OP_DIV_INIT;
      S_DIV_STEP:  cmd.op = OP_DIV_STEP;
      S_CAP:       cmd.op = OP_CAP;
      S_DELTA:     cmd.op = OP_DELTA;
      S_UPDATE:    cmd.op = OP_UPDATE;
      S_RESID:     cmd.op = OP_RESID;
      S_RESID_CHK: cmd.op = OP_RESID_CHK;
      S_EMIT:      cmd.op = emit_ok ? OP_EMIT : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_START;
      cnt_r       <= '0;
      count_r     <= '0;
      conv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            count_r <= '0;
            conv_r  <= 1'b0;
            phase_r <= PH_START;
            state_r <= S_RED_INIT;
          end
        end
        S_RED_INIT: begin
          cnt_r   <= CNT_W'(RED_STEPS - 1);
          state_r <= S_RED_STEP;
        end
        S_RED_STEP: begin
          if (cnt_r == '0) state_r <= S_RED_SIGN;
          else cnt_r <= cnt_r - 1'b1;
        end
        S_RED_SIGN: state_r <= S_FOLD_PI;
        S_FOLD_PI:  state_r <= S_FOLD_HALF;
        S_FOLD_HALF: begin
          cnt_r   <= '0;
          state_r <= S_CORDIC;
        end
        S_CORDIC: begin
          if (cnt_r == CNT_W'(CORDIC_STAGES - 1)) state_r <= S_MUL_PREP;
          else cnt_r <= cnt_r + 1'b1;
        end
        S_MUL_PREP: state_r <= S_MUL_LO;
        S_MUL_LO:   state_r <= S_MUL_HI;
        S_MUL_HI:   state_r <= S_MUL_SIGN;
        S_MUL_SIGN: begin
          case (phase_r)
            PH_START: state_r <= S_START;
            PH_SIN:   state_r <= S_FUNC;
            PH_COS:   state_r <= S_DERIV;
            default:  state_r <= S_RESID;
          endcase
        end
        S_START: state_r <= S_LOOP;
        S_LOOP: begin
          phase_r <= (conv_r || count_r >= iter_limit) ? PH_RESID : PH_SIN;
          state_r <= S_RED_INIT;
        end
        S_FUNC: begin
          // CORDIC x still holds cos of the same angle
          phase_r <= PH_COS;
          state_r <= S_MUL_PREP;
        end
        S_DERIV: state_r <= S_DIV_INIT;
        S_DIV_INIT: begin
          cnt_r   <= '0;
          state_r <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          if (cnt_r == CNT_W'(DIV_BITS - 1)) state_r <= S_CAP;
          else cnt_r <= cnt_r + 1'b1;
        end
        S_CAP:   state_r <= S_DELTA;
        S_DELTA: state_r <= S_UPDATE;
        S_UPDATE: begin
          count_r <= count_r + 1'b1;
          state_r <= S_STEP_CHK;
        end
        S_STEP_CHK: begin
          conv_r  <= status.step_small;
          state_r <= S_LOOP;
        end
        S_RESID:     state_r <= S_RESID_CHK;
        S_RESID_CHK: state_r <= S_EMIT;
        S_EMIT: begin
          if (emit_ok) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      // set on emit, cleared once the sink takes the result
      out_valid_r <= (state_r == S_EMIT && emit_ok) || (out_valid_r && !out_ready);
    end
  end

endmodule

>>> rtl/kepler_equation_newton_solver_unit.sv
// Kepler equation Newton solver, top level: configuration registers plus the
// controller (kens_ctrl) and datapath (kens_datapath). Uses kens_pkg.
//
// Each sin/cos runs a 5-step mod 2pi reduction, the folds and 44 CORDIC
// stages; each Newton step adds a restoring divide. The number of Newton
// steps run is 0..iteration_limit. One item in flight; the next transaction
// is taken the cycle after the result is loaded into the output register.
// Reset (rst_n low, synchronous): idle, no result pending, registers at
// step_tolerance 110, iteration_limit 100, residual_tolerance 191900.
module kepler_equation_newton_solver_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  kens_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output kens_pkg::out_item_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [kens_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [kens_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import kens_pkg::*;

  // Configuration; the user must write it only while no transaction is in flight; the block does not enforce this.
  logic [STEP_TOL_W-1:0]  step_tol_r;
  logic [COUNT_W-1:0]     iter_limit_r;
  logic [RESID_TOL_W-1:0] resid_tol_r;

  dp_cmd_t    cmd;
  dp_status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_tol_r   <= STEP_TOL_RST;
      iter_limit_r <= ITER_LIM_RST;
      resid_tol_r  <= RESID_TOL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_TOL:   step_tol_r   <= cfg_data[STEP_TOL_W-1:0];
        CFG_ITER_LIMIT: iter_limit_r <= cfg_data[COUNT_W-1:0];
        CFG_RESID_TOL:  resid_tol_r  <= cfg_data[RESID_TOL_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // Sequencer: walks reduction -> CORDIC -> multiply -> divide -> update
  kens_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .iter_limit (iter_limit_r),
    .status     (status),
    .cmd        (cmd)
  );

  // Arithmetic; holds the output register that out_data shows
  kens_datapath u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .in_data   (in_data),
    .step_tol  (step_tol_r),
    .resid_tol (resid_tol_r),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

>>> rtl/kens_checker.sv
// Port-level checks for the Kepler Newton solver, bound to the top level.
// Uses kens_pkg.
module kens_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input kens_pkg::out_item_t out_data
);
  import kens_pkg::*;

  // A result waiting on the sink keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One transaction at a time: busy right after accepting.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  // A new result only appears when leaving the busy phase.
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready) && in_ready)
    else $error("result without a finished transaction");

  // Convergence needs at least one Newton step.
  a_conv_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.limit_reached |-> out_data.iterations_used != '0)
    else $error("converged with zero iterations");

endmodule

bind kepler_equation_newton_solver_unit kens_checker u_kens_checker (.*);

>>> test/kens_solver_checker.sv
// Checker for the Kepler Newton solver: watches the input, result and
// configuration ports, predicts each solution and compares it field by field.
// Depends on kens_pkg for the payload types and port widths.
`timescale 1ns / 100ps

module kens_solver_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  kens_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  kens_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [kens_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kens_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              solutions_pending
);
  import kens_pkg::*;

  typedef logic signed [63:0] fix_t;

  localparam int   FRAC   = 60;
  localparam int   ASHIFT = 20;
  localparam fix_t UNIT   = fix_t'(1) << FRAC;
  localparam fix_t ANG_HI = (fix_t'(1) << 47) - 1;
  localparam fix_t ANG_LO = -(fix_t'(1) << 47);

  // Own copy of the trig constants and of the register file
  fix_t        pi_k, half_pi_k, two_pi_k, gain_k;
  fix_t        arc_k [CORDIC_STAGES];
  logic [19:0] step_tol_q;
  logic [7:0]  iter_lim_q;
  logic [23:0] resid_tol_q;
  out_item_t   solution_q [$];

  function automatic logic [63:0] div_sat(logic [127:0] num, logic [63:0] d);
    if (d == '0 || num[127:64] >= d) return '1;
    return 64'(num / d);
  endfunction

  function automatic logic [63:0] round_angle(logic [63:0] v);
    return (v + (64'd1 << (ASHIFT - 1))) >> ASHIFT;
  endfunction

  function automatic logic [63:0] arctan_series(logic [63:0] t0, logic [63:0] dv, int sh);
    logic [63:0] t;
    logic [63:0] acc;
    logic [63:0] k;
    t   = t0;
    acc = '0;
    k   = '0;
    while (t != '0) begin
      if (k[0]) acc = acc - t / (2 * k + 1);
      else      acc = acc + t / (2 * k + 1);
      if (dv != '0)    t = t / dv;
      else if (sh < 64) t = t >> sh;
      else             t = '0;
      k++;
    end
    return acc;
  endfunction

  initial begin
    logic [63:0] one, quarter, p, s, q, ns;
    one     = 64'd1 << FRAC;
    quarter = 4 * arctan_series(one / 5, 64'd25, 0) - arctan_series(one / 239, 64'd57121, 0);
    arc_k[0] = fix_t'(round_angle(quarter));
    p = 64'd1 << (FRAC + 1);
    s = 64'd1 << (FRAC + 1);
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      arc_k[i] = fix_t'(round_angle(arctan_series(64'd1 << (FRAC - i), 64'd0, 2 * i)));
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    pi_k      = fix_t'(round_angle(4 * quarter));
    half_pi_k = fix_t'(round_angle(2 * quarter));
    two_pi_k  = fix_t'(round_angle(8 * quarter));
    for (int k = 0; k < 80; k++) begin
      q  = div_sat(128'(p) << 60, s);
      ns = (s + q) >> 1;
      if (ns >= s) break;
      s = ns;
    end
    gain_k = fix_t'(div_sat(128'd1 << 120, s));
  end

  // Rotation CORDIC after reduction mod 2pi and folding into +-pi/2
  task automatic rotate(input fix_t a, output fix_t sn, output fix_t cs);
    fix_t r, x, y, dx, dy;
    logic flip;
    r    = a % two_pi_k;
    x    = gain_k;
    y    = '0;
    flip = 1'b0;
    if (r > pi_k)       r = r - two_pi_k;
    else if (r < -pi_k) r = r + two_pi_k;
    if (r > half_pi_k) begin
      r    = pi_k - r;
      flip = 1'b1;
    end else if (r < -half_pi_k) begin
      r    = -pi_k - r;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (r >= 0) begin
        x = x - dx; y = y + dy; r = r - arc_k[i];
      end else begin
        x = x + dx; y = y - dy; r = r + arc_k[i];
      end
    end
    sn = y;
    cs = flip ? -x : x;
  endtask

  // e times v, truncated toward zero
  function automatic fix_t scale_by_ecc(logic [31:0] e, fix_t v);
    logic [63:0]  mag;
    logic [127:0] prod;
    mag  = v < 0 ? 64'(-v) : 64'(v);
    prod = 128'(e) * 128'(mag);
    return v < 0 ? -fix_t'(prod[95:32]) : fix_t'(prod[95:32]);
  endfunction

  function automatic fix_t clamp_angle(fix_t v);
    return v > ANG_HI ? ANG_HI : (v < ANG_LO ? ANG_LO : v);
  endfunction

  task automatic solve_kepler(input in_item_t it, output out_item_t sol);
    fix_t        m, ea, sn, cs, f, fp, dl, ne, st, res;
    logic [31:0] e;
    logic [63:0] fmag, q;
    logic [7:0]  n;
    logic        conv;
    m    = fix_t'(it.mean_anomaly);
    e    = it.eccentricity;
    n    = '0;
    conv = 1'b0;
    rotate(m, sn, cs);
    ea = clamp_angle(m + (scale_by_ecc(e, sn) >>> ASHIFT));
    while (!conv && n < iter_lim_q) begin
      rotate(ea, sn, cs);
      f  = ea - m - (scale_by_ecc(e, sn) >>> ASHIFT);
      fp = UNIT - scale_by_ecc(e, cs);
      if (fp < 1) fp = 1;
      fmag = f < 0 ? 64'(-f) : 64'(f);
      q    = div_sat(128'(fmag) << 60, 64'(fp));
      if (q > STEP_CAP) q = STEP_CAP;
      dl = f < 0 ? -fix_t'(q) : fix_t'(q);
      ne = clamp_angle(ea - dl);
      st = ne - ea;
      if (st < 0) st = -st;
      ea   = ne;
      n    = n + 1;
      conv = st <= fix_t'(step_tol_q);
    end
    rotate(ea, sn, cs);
    res = ea - (scale_by_ecc(e, sn) >>> ASHIFT) - m;
    if (res < 0) res = -res;
    sol.eccentric_anomaly = ea[47:0];
    sol.solution_valid    = res <= fix_t'(resid_tol_q);
    sol.iterations_used   = n;
    sol.limit_reached     = !conv;
  endtask

  assign solutions_pending = solution_q.size();

  always @(posedge clk) begin
    out_item_t sol;
    out_item_t want;
    if (!rst_n) begin
      step_tol_q     <= STEP_TOL_RST;
      iter_lim_q     <= ITER_LIM_RST;
      resid_tol_q    <= RESID_TOL_RST;
      mismatch_count <= 0;
      solution_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_STEP_TOL:   step_tol_q  <= cfg_data[STEP_TOL_W-1:0];
          CFG_ITER_LIMIT: iter_lim_q  <= cfg_data[COUNT_W-1:0];
          CFG_RESID_TOL:  resid_tol_q <= cfg_data[RESID_TOL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        solve_kepler(in_data, sol);
        solution_q.push_back(sol);
      end
      if (out_valid && out_ready) begin
        if (solution_q.size() == 0) begin
          $error("unexpected result transaction %h", out_data);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = solution_q.pop_front();
          if (out_data.eccentric_anomaly !== want.eccentric_anomaly ||
              out_data.solution_valid !== want.solution_valid ||
              out_data.iterations_used !== want.iterations_used ||
              out_data.limit_reached !== want.limit_reached)
            mismatch_count <= mismatch_count + 1;
          if (out_data.eccentric_anomaly !== want.eccentric_anomaly)
            $error("eccentric_anomaly: expected %0d, got %0d",
                   want.eccentric_anomaly, out_data.eccentric_anomaly);
          if (out_data.solution_valid !== want.solution_valid)
            $error("solution_valid: expected %0d, got %0d",
                   want.solution_valid, out_data.solution_valid);
          if (out_data.iterations_used !== want.iterations_used)
            $error("iterations_used: expected %0d, got %0d",
                   want.iterations_used, out_data.iterations_used);
          if (out_data.limit_reached !== want.limit_reached)
            $error("limit_reached: expected %0d, got %0d",
                   want.limit_reached, out_data.limit_reached);
        end
      end
    end
  end

endmodule

>>> test/tb_kepler_equation_newton_solver_unit.sv
// Top of the Kepler Newton solver testbench: clock, reset, stimulus,
// configuration phases and verdict. Depends on kens_pkg, the solver
// and kens_solver_checker.
`timescale 1ns / 100ps

module tb_kepler_equation_newton_solver_unit;
  import kens_pkg::*;

  localparam logic signed [47:0] ANG_POS_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ANG_NEG_MAX = 48'sh8000_0000_0000;
  localparam logic signed [47:0] PI_APPROX   = 48'sd3454217652358;  // pi * 2^40
  localparam logic [31:0]        ECC_MAX     = 32'hFFFF_FFFF;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     mismatch_count;
  int                     solutions_pending;
  // Result-side backpressure; quiet phases turn it off for a stretch
  logic                   sink_quiet = 1'b0;
  int                     stall_left = 0;

  always #4 clk = ~clk;

  kepler_equation_newton_solver_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kens_solver_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .solutions_pending (solutions_pending)
  );

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(4, 1);
    return $urandom_range(200, 20);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!sink_quiet && $urandom_range(3) == 0) stall_left <= gap_len();
    end
  end

  // Valid is held high between back-to-back transactions; it only drops
  // when a gap is inserted, so it never gets two updates in one step.
  task automatic send_anomaly(input logic signed [47:0] m, input logic [31:0] e);
    int gap;
    gap = sink_quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mean_anomaly: m, eccentricity: e};
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Drain all results, then program all three registers
  task automatic program_solver(input logic [19:0] step_tol, input logic [7:0] iter_lim,
                                input logic [23:0] resid_tol);
    in_valid <= 1'b0;
    @(posedge clk);
    while (solutions_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STEP_TOL;
    cfg_data  <= 24'(step_tol);
    @(posedge clk);
    cfg_index <= CFG_ITER_LIMIT;
    cfg_data  <= 24'(iter_lim);
    @(posedge clk);
    cfg_index <= CFG_RESID_TOL;
    cfg_data  <= resid_tol;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_anomaly();
    logic signed [47:0] m;
    logic [31:0]        e;
    int                 r;
    r = $urandom_range(9);
    if (r < 2) m = 48'({$urandom, $urandom});
    else       m = 48'($signed({$urandom, $urandom}) >>> 19);  // within about +-5pi
    r = $urandom_range(9);
    if (r < 5)      e = $urandom;
    else if (r < 7) e = ECC_MAX - $urandom_range(65535);  // nearly parabolic
    else if (r < 9) e = $urandom_range(32'h3FFF_FFFF);
    else            e = $urandom_range(15);
    send_anomaly(m, e);
  endtask

  // Directed corners under the current register settings
  task automatic send_corners();
    send_anomaly('0, '0);
    send_anomaly(ANG_POS_MAX, '0);
    send_anomaly(ANG_NEG_MAX, '0);
    send_anomaly(ANG_POS_MAX, ECC_MAX);
    send_anomaly(ANG_NEG_MAX, ECC_MAX);
    send_anomaly(PI_APPROX, 32'h8000_0000);
    send_anomaly(-PI_APPROX, 32'h8000_0000);
    send_anomaly(PI_APPROX, ECC_MAX);
    send_anomaly(2 * PI_APPROX, 32'h4000_0000);
    send_anomaly(48'sd1, ECC_MAX);
    send_anomaly(-48'sd1, ECC_MAX);
    send_anomaly(48'sd1 <<< 30, 32'd1);
    send_anomaly(PI_APPROX >>> 1, 32'hF000_0000);
  endtask

  initial begin
    #300_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values first, then the register extremes
    send_corners();
    program_solver('0, '0, '0);          // zero iteration limit: start value only
    send_corners();
    program_solver(20'hFFFFF, 8'd1, 24'hFFFFFF);
    send_corners();
    program_solver('0, 8'd255, 24'd1000);
    repeat (8) send_random_anomaly();

    // Random settings; one phase with no backpressure or gaps
    for (int ph = 0; ph < 6; ph++) begin
      sink_quiet <= (ph == 2);
      program_solver(($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(2000)),
                     8'($urandom_range(40, 1)),
                     ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(400000)));
      repeat (90) send_random_anomaly();
    end
    sink_quiet <= 1'b0;
    program_solver(STEP_TOL_RST, ITER_LIM_RST, RESID_TOL_RST);
    repeat (20) send_random_anomaly();

    in_valid <= 1'b0;
    @(posedge clk);
    while (solutions_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
